### rtl/core/text_console_cursor_scroll_defines.svh
// Assertion macros for the checker file of the text console.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define TCCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tccs_pkg.sv
// Types and constants shared by the text console modules.
package tccs_pkg;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [15:0] RESET_BLANK = 16'h0720;

  localparam logic [1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [1:0] CFG_ROWS      = 2'd1;
  localparam logic [1:0] CFG_TAB       = 2'd2;
  localparam logic [1:0] CFG_ATTRIBUTE = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BLANK,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic       wrote;
    logic       scroll;
  } step_t;

endpackage

### rtl/core/tccs_cursor_step.sv
// Cursor update for one item: control codes, wrap and scroll decision.
module tccs_cursor_step (
  input  logic [6:0]      col_in,
  input  logic [4:0]      row_in,
  input  logic [6:0]      cols,
  input  logic [4:0]      rows,
  input  logic [3:0]      tab,
  input  logic            command,
  input  logic [7:0]      character,
  output tccs_pkg::step_t step
);
  import tccs_pkg::*;

  logic [7:0] col_w;
  logic [5:0] row_w;
  logic       wrote;
  logic       scroll;

  always_comb begin
    col_w  = {1'b0, col_in};
    row_w  = {1'b0, row_in};
    wrote  = 1'b0;
    scroll = 1'b0;
    if (command) begin
      col_w = '0;
      row_w = '0;
    end else begin
      priority if (character == CH_NEWLINE) begin
        col_w = '0;
        row_w = row_w + 6'd1;
      end else if (character == CH_RETURN) begin
        col_w = '0;
      end else if (character == CH_BACKSPACE) begin
        if (col_w != '0) col_w = col_w - 8'd1;
      end else if (character == CH_TAB) begin
        col_w = col_w + {4'b0, tab};
      end else begin
        wrote = 1'b1;
        col_w = col_w + 8'd1;
      end
      if (col_w > ({1'b0, cols} - 8'd1)) begin
        col_w = '0;
        row_w = row_w + 6'd1;
      end
      // Running off the bottom scrolls and parks the cursor on the last row.
      if (row_w > ({1'b0, rows} - 6'd1)) begin
        scroll = 1'b1;
        col_w  = '0;
        row_w  = {1'b0, rows} - 6'd1;
      end
    end
    step.col    = col_w[6:0];
    step.row    = row_w[4:0];
    step.wrote  = wrote;
    step.scroll = scroll;
  end

endmodule

### rtl/core/text_console_cursor_scroll.sv
// Text console: cursor sequencer, screen store and configuration registers.
//
// Usage: an item (command, character) is taken at a clock edge where start is
// high and busy is low. One result per item appears on the result ports for a
// single cycle with done high; the receiver cannot stall it, and start may be
// raised again in that same done cycle.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), taken at
// any edge with cfg_we high; it should only be used while busy is low.
// Steps per item, set by the single screen store port and the one address unit:
//   printable byte or cursor move without scroll: ST_EXEC, then back to idle;
//   clear command: ST_EXEC, then ST_FILL writes rows*columns blanks, one per cycle;
//   scroll: ST_EXEC, then each of the (rows-1)*columns moved cells is
//   read in ST_COPY_RD and written one row up in ST_COPY_WR, then the
//   bottom row is blanked in ST_BLANK, one cell per cycle.
// After reset the block sweeps all MAX_COLUMNS*MAX_ROWS cells of the store,
// writing blanks with attribute 7 and holding busy high; configuration writes
// are taken during that sweep.
module text_console_cursor_scroll #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [7:0]  character,
  output logic        done,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  output logic        wrote_cell,
  output logic [10:0] cell_index,
  output logic [15:0] cell_value,
  output logic        scrolled,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tccs_pkg::*;

  localparam int STORE  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(STORE);
  localparam int PTR_W  = $clog2(STORE + MAX_COLUMNS + 1);

  // Configuration registers.
  logic [6:0] screen_columns;
  logic [4:0] screen_rows;
  logic [3:0] tab_width;
  logic [7:0] cell_attribute;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= 7'd80;
      screen_rows    <= 5'd25;
      tab_width      <= 4'd2;
      cell_attribute <= 8'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS:   screen_columns <= cfg_data[6:0];
        CFG_ROWS:      screen_rows    <= cfg_data[4:0];
        CFG_TAB:       tab_width      <= cfg_data[3:0];
        CFG_ATTRIBUTE: cell_attribute <= cfg_data;
      endcase
    end
  end

  // Geometry in effect, clamped to at least 1 column and 2 rows and to the store's shape.
  logic [6:0] cols_eff;
  logic [4:0] rows_eff;

  always_comb begin
    if (screen_columns == '0) cols_eff = 7'd1;
    else if (int'(screen_columns) > MAX_COLUMNS) cols_eff = 7'(MAX_COLUMNS);
    else cols_eff = screen_columns;
    if (screen_rows < 5'd2) rows_eff = 5'd2;
    else if (int'(screen_rows) > MAX_ROWS) rows_eff = 5'(MAX_ROWS);
    else rows_eff = screen_rows;
  end

  // Sequencer and working registers.
  state_t           state, state_next;
  logic [6:0]       cursor_col;
  logic [4:0]       cursor_line;
  logic             cmd_q;
  logic [7:0]       char_q;
  logic [6:0]       col_q;
  logic [4:0]       row_q;
  logic [PTR_W-1:0] limit;
  logic [PTR_W-1:0] ptr;
  logic [15:0]      rdata;

  // Shared multiplier: screen size while idle, row offset during execution.
  logic [4:0]  mul_a;
  logic [11:0] mul_p;
  logic [11:0] idx;

  assign mul_a = (state == ST_IDLE) ? rows_eff : row_q;
  assign mul_p = 12'(mul_a * cols_eff);
  assign idx   = mul_p + {5'b0, col_q};

  step_t step;

  tccs_cursor_step u_step (
    .col_in    (col_q),
    .row_in    (row_q),
    .cols      (cols_eff),
    .rows      (rows_eff),
    .tab       (tab_width),
    .command   (cmd_q),
    .character (char_q),
    .step      (step)
  );

  logic             accept;
  logic [PTR_W-1:0] ptr_back;
  logic [PTR_W-1:0] cols_w;

  assign accept   = (state == ST_IDLE) && start;
  assign cols_w   = PTR_W'(cols_eff);
  assign ptr_back = ptr - cols_w;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:    if (ptr == PTR_W'(STORE - 1)) state_next = ST_IDLE;
      ST_IDLE:    if (start) state_next = ST_EXEC;
      ST_EXEC: begin
        if (cmd_q) state_next = ST_FILL;
        else if (step.scroll) state_next = ST_COPY_RD;
        else state_next = ST_IDLE;
      end
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: state_next = (ptr + 1'b1 == limit) ? ST_BLANK : ST_COPY_RD;
      ST_BLANK:   if (ptr + 1'b1 == limit + cols_w) state_next = ST_IDLE;
      ST_FILL:    if (ptr + 1'b1 == limit) state_next = ST_IDLE;
      default:    state_next = ST_INIT;
    endcase
  end

  // Store port and pointer control.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              ptr_inc;
  logic              done_next;
  logic [15:0]       blank;

  assign blank = {cell_attribute, CH_SPACE};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(ptr);
    mem_wdata = blank;
    ptr_inc   = 1'b0;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_BLANK;
        ptr_inc   = 1'b1;
      end
      ST_EXEC: begin
        mem_we    = step.wrote;
        mem_waddr = ADDR_W'(idx);
        mem_wdata = {cell_attribute, char_q};
      end
      ST_COPY_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(ptr_back);
        mem_wdata = rdata;
        ptr_inc   = 1'b1;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(ptr_back);
        ptr_inc   = 1'b1;
      end
      ST_FILL: begin
        mem_we  = 1'b1;
        ptr_inc = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    done_next = (state != ST_IDLE) && (state != ST_INIT) && (state_next == ST_IDLE);
  end

  // Screen store.
  logic [15:0] mem [STORE];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[ADDR_W'(ptr)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      ptr         <= '0;
      cursor_col  <= '0;
      cursor_line <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == ST_EXEC) begin
        cursor_col  <= step.col;
        cursor_line <= step.row;
        ptr         <= cmd_q ? '0 : cols_w;
      end else if (ptr_inc) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // Item capture and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      char_q <= character;
      col_q  <= (cursor_col > cols_eff - 7'd1) ? cols_eff - 7'd1 : cursor_col;
      row_q  <= (cursor_line > rows_eff - 5'd1) ? rows_eff - 5'd1 : cursor_line;
      limit  <= PTR_W'(mul_p);
    end
    if (state == ST_EXEC) begin
      cursor_column <= step.col;
      cursor_row    <= step.row;
      wrote_cell    <= step.wrote;
      cell_index    <= step.wrote ? idx[10:0] : 11'd0;
      cell_value    <= step.wrote ? {cell_attribute, char_q} : 16'd0;
      scrolled      <= step.scroll;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

### rtl/core/tccs_checker.sv
// Port-level checker for the text console, bound to the top level.
module tccs_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [6:0]  cursor_column,
  input logic        wrote_cell,
  input logic [10:0] cell_index,
  input logic [15:0] cell_value,
  input logic        scrolled
);
`include "text_console_cursor_scroll_defines.svh"

  `TCCS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `TCCS_ASSERT_NOW(a_done_idle, done, !busy && $past(busy), "result strobe outside item end")
  `TCCS_ASSERT_NOW(a_no_write_zero, done && !wrote_cell, cell_index == 11'd0 && cell_value == 16'd0, "cell fields set without a write")
  `TCCS_ASSERT_NOW(a_scroll_home, done && scrolled, cursor_column == 7'd0, "scroll left cursor off column zero")

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .cursor_column (cursor_column),
  .wrote_cell    (wrote_cell),
  .cell_index    (cell_index),
  .cell_value    (cell_value),
  .scrolled      (scrolled)
);
